// ===== src/flt_pkg.sv =====
`default_nettype none
package flt_pkg;

  // Field widths of the request, result and table entry items
  localparam int TYPE_W = 3;
  localparam int ID_W   = 10;
  localparam int WHO_W  = 8;
  localparam int STAT_W = 2;
  localparam int ENT_ST_W = 2;
  localparam int ENT_W  = ENT_ST_W + WHO_W;

  // Request kinds; codes above modify behave as modify
  typedef enum logic [TYPE_W-1:0] {
    REQ_CREATE   = 3'd0,
    REQ_SELECT   = 3'd1,
    REQ_DESELECT = 3'd2,
    REQ_DELETE   = 3'd3,
    REQ_MODIFY   = 3'd4
  } req_type_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_OWNER = 2'd1,
    STS_DELETED   = 2'd2,
    STS_EXHAUSTED = 2'd3
  } status_t;

  // Per-object lock state
  typedef enum logic [ENT_ST_W-1:0] {
    ENT_FREE = 2'd0,
    ENT_HELD = 2'd1,
    ENT_DEAD = 2'd2
  } ent_state_t;

  // Controller states
  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear;   // write zero at the sweep counter
    logic accept;  // capture request, launch table read
    logic exec;    // resolve request, update table, load result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_done;  // sweep is at the last entry
    logic out_free;  // result register can take a new result
  } sts_t;

endpackage
`default_nettype wire

// ===== src/flt_ram.sv =====
`default_nettype none
module flt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // One write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/flt_ctrl.sv =====
`default_nettype none
module flt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire flt_pkg::sts_t sts,
  output flt_pkg::cmd_t      cmd
);

  flt_pkg::ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= flt_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      flt_pkg::S_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = flt_pkg::S_IDLE;
        end
      end
      flt_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = flt_pkg::S_EXEC;
        end
      end
      flt_pkg::S_EXEC: begin
        if (sts.out_free) begin
          state_nxt = flt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = flt_pkg::S_CLEAR;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      flt_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
      end
      flt_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      flt_pkg::S_EXEC: begin
        cmd.exec = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/flt_dpath.sv =====
`default_nettype none
module flt_dpath #(
  parameter int OBJECTS = 1024,
  parameter int CLIENTS = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire flt_pkg::cmd_t                cmd,
  output flt_pkg::sts_t                     sts,
  input  wire logic                         cfg_we,
  input  wire logic [flt_pkg::ID_W-1:0]     cfg_start_id,
  input  wire logic [flt_pkg::TYPE_W-1:0]   in_req_type,
  input  wire logic [flt_pkg::ID_W-1:0]     in_figure_id,
  input  wire logic [flt_pkg::WHO_W-1:0]    in_requester,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_accepted,
  output logic      [flt_pkg::STAT_W-1:0]   out_status,
  output logic      [flt_pkg::ID_W-1:0]     out_result_id,
  output logic      [flt_pkg::TYPE_W-1:0]   out_result_type,
  output logic      [flt_pkg::WHO_W-1:0]    out_result_requester
);

  localparam int AW = $clog2(OBJECTS);
  // Id counter is wide enough for both the register and the table
  localparam int LW = (AW > flt_pkg::ID_W) ? AW : flt_pkg::ID_W;

  // Captured request
  logic [flt_pkg::TYPE_W-1:0] type_r;
  logic [flt_pkg::ID_W-1:0]   id_r;
  logic [flt_pkg::WHO_W-1:0]  who_r;

  logic [LW-1:0] last_id_r;
  logic [AW-1:0] clr_cnt_r;
  logic          out_valid_r;

  // Table port signals
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [flt_pkg::ENT_W-1:0] ram_wdata;
  logic [flt_pkg::ENT_W-1:0] ram_rdata;

  // Resolved request
  logic                       res_acc;
  logic [flt_pkg::STAT_W-1:0] res_status;
  logic [flt_pkg::ID_W-1:0]   res_id;
  logic                       ent_we;
  logic [AW-1:0]              ent_addr;
  logic [flt_pkg::ENT_W-1:0]  ent_data;
  logic                       id_bump;

  logic [LW:0]                  next_id;
  logic                         who_ok;
  logic                         id_ok;
  logic                         can_create;
  logic [flt_pkg::ENT_ST_W-1:0] rd_state;
  logic [flt_pkg::WHO_W-1:0]    rd_holder;
  logic                         mine;

  flt_ram #(
    .WIDTH (flt_pkg::ENT_W),
    .DEPTH (OBJECTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (AW'(in_figure_id)),
    .rdata (ram_rdata)
  );

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      type_r <= in_req_type;
      id_r   <= in_figure_id;
      who_r  <= in_requester;
    end
  end

  // Clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // Highest id in use
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_id_r <= '0;
    end else if (cfg_we) begin
      last_id_r <= LW'(cfg_start_id);
    end else if (id_bump) begin
      last_id_r <= next_id[LW-1:0];
    end
  end

  // Request checks
  always_comb begin
    next_id    = {1'b0, last_id_r} + (LW+1)'(1);
    who_ok     = 32'(who_r) < CLIENTS;
    id_ok      = 32'(id_r) < OBJECTS;
    can_create = 32'(next_id) < OBJECTS;
    rd_state   = ram_rdata[flt_pkg::ENT_W-1:flt_pkg::WHO_W];
    rd_holder  = ram_rdata[flt_pkg::WHO_W-1:0];
    mine       = (rd_state == flt_pkg::ENT_HELD) && (rd_holder == who_r);
  end

  // Resolve request against the entry
  always_comb begin
    res_acc    = 1'b0;
    res_status = flt_pkg::STS_NOT_OWNER;
    res_id     = id_r;
    ent_we     = 1'b0;
    ent_addr   = AW'(id_r);
    ent_data   = '0;
    id_bump    = 1'b0;
    if (type_r == flt_pkg::REQ_CREATE) begin
      res_id = '0;
      if (!who_ok) begin
        res_status = flt_pkg::STS_NOT_OWNER;
      end else if (!can_create) begin
        res_status = flt_pkg::STS_EXHAUSTED;
      end else begin
        res_acc    = 1'b1;
        res_status = flt_pkg::STS_OK;
        res_id     = next_id[flt_pkg::ID_W-1:0];
        ent_we     = cmd.exec;
        ent_addr   = AW'(next_id);
        ent_data   = {flt_pkg::ENT_HELD, who_r};
        id_bump    = cmd.exec;
      end
    end else if (!id_ok || !who_ok) begin
      res_status = flt_pkg::STS_NOT_OWNER;
    end else if (rd_state == flt_pkg::ENT_DEAD) begin
      res_status = flt_pkg::STS_DELETED;
    end else begin
      case (type_r)
        flt_pkg::REQ_SELECT: begin
          if (rd_state != flt_pkg::ENT_HELD) begin
            res_acc    = 1'b1;
            res_status = flt_pkg::STS_OK;
            ent_we     = cmd.exec;
            ent_data   = {flt_pkg::ENT_HELD, who_r};
          end else if (mine) begin
            res_acc    = 1'b1;
            res_status = flt_pkg::STS_OK;
          end
        end
        flt_pkg::REQ_DESELECT: begin
          if (mine) begin
            res_acc    = 1'b1;
            res_status = flt_pkg::STS_OK;
            ent_we     = cmd.exec;
            ent_data   = {flt_pkg::ENT_FREE, flt_pkg::WHO_W'(0)};
          end
        end
        flt_pkg::REQ_DELETE: begin
          if (mine) begin
            res_acc    = 1'b1;
            res_status = flt_pkg::STS_OK;
            ent_we     = cmd.exec;
            ent_data   = {flt_pkg::ENT_DEAD, flt_pkg::WHO_W'(0)};
          end
        end
        default: begin
          // modify and unused kinds: holder check only
          if (mine) begin
            res_acc    = 1'b1;
            res_status = flt_pkg::STS_OK;
          end
        end
      endcase
    end
  end

  // Table write mux: sweep or request update
  always_comb begin
    ram_we    = cmd.clear | ent_we;
    ram_waddr = cmd.clear ? clr_cnt_r : ent_addr;
    ram_wdata = cmd.clear ? '0 : ent_data;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_accepted         <= res_acc;
      out_status           <= res_status;
      out_result_id        <= res_id;
      out_result_type      <= type_r;
      out_result_requester <= who_r;
    end
  end

  assign out_valid = out_valid_r;

  // Status to the controller
  always_comb begin
    sts          = '0;
    sts.out_free = !out_valid_r || !out_stall;
    sts.clr_done = clr_cnt_r == AW'(OBJECTS - 1);
  end

endmodule
`default_nettype wire

// ===== src/figure_lock_table.sv =====
// Ownership lock table for shared objects.
// Input channel (in_valid / in_stall): one request per item, naming a kind
// (create, select, deselect, delete, modify), an object id and a requester.
// Result channel (out_valid / out_stall): exactly one result per request,
// in request order, with accept flag, status, id and echoed fields.
// Config: cfg_we loads cfg_start_id as the highest id in use; the next
// create gets the following id. Write it only while the block is idle.
// Timing: a request is taken and its table entry is read into the registered
// read port; the request is then resolved, and the result is registered
// once the result register is free. A new request is taken only after the
// last is resolved, set by the read-then-write of the single-port-pair
// table memory. in_stall is high while a request is in flight.
// Reset: synchronous, active low. After reset the table is swept to free,
// one entry per cycle, across all OBJECTS entries, with in_stall held high.
// Stall: a pending result holds on out_stall; one more request may be taken,
// and it waits unresolved until the result register frees up.
`default_nettype none
module figure_lock_table #(
  parameter int OBJECTS = 1024,
  parameter int CLIENTS = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [flt_pkg::ID_W-1:0]     cfg_start_id,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [flt_pkg::TYPE_W-1:0]   in_req_type,
  input  wire logic [flt_pkg::ID_W-1:0]     in_figure_id,
  input  wire logic [flt_pkg::WHO_W-1:0]    in_requester,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_accepted,
  output logic      [flt_pkg::STAT_W-1:0]   out_status,
  output logic      [flt_pkg::ID_W-1:0]     out_result_id,
  output logic      [flt_pkg::TYPE_W-1:0]   out_result_type,
  output logic      [flt_pkg::WHO_W-1:0]    out_result_requester
);

  flt_pkg::cmd_t cmd;
  flt_pkg::sts_t sts;

  // Sequencer
  flt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, id counter and result register
  flt_dpath #(
    .OBJECTS (OBJECTS),
    .CLIENTS (CLIENTS)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_start_id         (cfg_start_id),
    .in_req_type          (in_req_type),
    .in_figure_id         (in_figure_id),
    .in_requester         (in_requester),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_accepted         (out_accepted),
    .out_status           (out_status),
    .out_result_id        (out_result_id),
    .out_result_type      (out_result_type),
    .out_result_requester (out_result_requester)
  );

endmodule
`default_nettype wire

// ===== src/flt_checker.sv =====
`default_nettype none
module flt_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic                         out_accepted,
  input wire logic [flt_pkg::STAT_W-1:0]   out_status,
  input wire logic [flt_pkg::ID_W-1:0]     out_result_id,
  input wire logic [flt_pkg::TYPE_W-1:0]   out_result_type
);

  // A stalled result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Accept flag and status agree
  a_acc_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_accepted == (out_status == flt_pkg::STS_OK)))
    else $error("accept flag does not match status");

  // Only a create can run out of ids
  a_exhaust_create: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == flt_pkg::STS_EXHAUSTED |->
      out_result_type == flt_pkg::REQ_CREATE)
    else $error("ids exhausted on a non-create request");

  // A refused create reports id zero
  a_create_refused_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_type == flt_pkg::REQ_CREATE && !out_accepted |->
      out_result_id == '0)
    else $error("refused create with nonzero id");

  // One request in flight: the cycle after a take is always stalled
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous still in flight");

endmodule

bind figure_lock_table flt_checker u_flt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_accepted    (out_accepted),
  .out_status      (out_status),
  .out_result_id   (out_result_id),
  .out_result_type (out_result_type)
);
`default_nettype wire
